// ===== rtl/dbs_pkg.sv =====
// Shared types, constants and helper functions for the DSSS burst spreader.
// No dependencies; every other file refers to it by scoped names.
package dbs_pkg;

   localparam int CodeChipsMax      = 64;
   localparam int ChipWordW         = 64;
   localparam int ChipCountW        = 7;
   localparam int CrcW              = 16;
   localparam int CrcTop            = 15;
   localparam logic [15:0] CrcPoly  = 16'h1021;
   localparam int QueueDepthDefault = 4;
   localparam int CfgAddrW          = 6;
   localparam int CfgDataW          = 64;
   localparam int IdxW              = 6;

   typedef enum logic {
      OP_START = 1'b0,
      OP_BIT   = 1'b1
   } op_kind_type;

   typedef enum logic [2:0] {
      REG_ACQ_WORD    = 3'd0,
      REG_ACQ_LEN     = 3'd1,
      REG_ACQ_REPEATS = 3'd2,
      REG_SPREAD_WORD = 3'd3,
      REG_SPREAD_LEN  = 3'd4,
      REG_CRC_ENABLE  = 3'd5,
      REG_CRC_INIT    = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      CMD_PREAMBLE,
      CMD_BIT,
      CMD_BIT_TRAILER
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic             bit_val;
      logic [CrcW-1:0]  crc;
   } cmd_type;

   typedef struct packed {
      logic [ChipWordW-1:0]  acq_word;
      logic [ChipCountW-1:0] acq_len;
      logic [ChipCountW-1:0] acq_repeats;
      logic [ChipWordW-1:0]  spread_word;
      logic [ChipCountW-1:0] spread_len;
      logic                  crc_enable;
      logic [CrcW-1:0]       crc_init;
   } cfg_type;

   // saturate a length or repeat count at the code size
   function automatic logic [ChipCountW-1:0] clamp_len(input logic [ChipCountW-1:0] len);
      clamp_len = (len > ChipCountW'(CodeChipsMax)) ? ChipCountW'(CodeChipsMax) : len;
   endfunction

   function automatic logic [ChipWordW-1:0] chip_mask(input logic [ChipCountW-1:0] len);
      if (len >= ChipCountW'(ChipWordW)) begin
         chip_mask = '1;
      end else begin
         chip_mask = (ChipWordW'(1) << len[IdxW-1:0]) - ChipWordW'(1);
      end
   endfunction

   // one MSB-first step of CRC-16-CCITT
   function automatic logic [CrcW-1:0] crc_feed(input logic [CrcW-1:0] crc,
                                                input logic bit_in);
      logic fb;
      fb = crc[CrcTop] ^ bit_in;
      crc_feed = {crc[CrcW-2:0], 1'b0} ^ (fb ? CrcPoly : '0);
   endfunction

endpackage

// ===== rtl/dbs_if.sv =====
// Valid/ready channel interfaces for the spreader's request and result sides.
// Depends on dbs_pkg for field widths.
interface dbs_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic frame_bit;
   logic in_payload;
   logic last_bit;

   modport source(output valid, operation, frame_bit, in_payload, last_bit, input ready);
   modport sink(input valid, operation, frame_bit, in_payload, last_bit, output ready);
endinterface

interface dbs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [dbs_pkg::ChipWordW-1:0]     chip_word;
   logic [dbs_pkg::ChipCountW-1:0]    chip_count;
   logic                              is_preamble;
   logic                              is_trailer;
   logic                              run_last;

   modport source(output valid, chip_word, chip_count, is_preamble, is_trailer, run_last,
                  input ready);
   modport sink(input valid, chip_word, chip_count, is_preamble, is_trailer, run_last,
                output ready);
endinterface

// ===== rtl/dbs_front.sv =====
// Front end: accepts request items, keeps the CRC state and queues commands.
// Depends on dbs_pkg and dbs_if.
module dbs_front (
   input  logic               clock,
   input  logic               reset,
   dbs_req_if.sink            req,
   input  dbs_pkg::cfg_type   cfg,
   input  logic               q_full,
   output logic               push,
   output dbs_pkg::cmd_type   push_cmd
);

   logic [dbs_pkg::CrcW-1:0] crc_ff, crc_in;
   logic                     seen_ff, seen_in;
   logic                     accept;
   logic [dbs_pkg::CrcW-1:0] crc_upd;
   logic                     seen_upd;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      crc_upd  = req.in_payload ? dbs_pkg::crc_feed(crc_ff, req.frame_bit) : crc_ff;
      seen_upd = seen_ff | req.in_payload;
      crc_in   = crc_ff;
      seen_in  = seen_ff;
      push     = 1'b0;
      push_cmd.kind    = dbs_pkg::CMD_BIT;
      push_cmd.bit_val = req.frame_bit;
      push_cmd.crc     = crc_upd;
      if (accept) begin
         if (req.operation == dbs_pkg::OP_START) begin
            // burst start: reload, queue the preamble only if it has chips
            crc_in        = cfg.crc_init;
            seen_in       = 1'b0;
            push_cmd.kind = dbs_pkg::CMD_PREAMBLE;
            push          = (cfg.acq_len != '0) && (cfg.acq_repeats != '0);
         end else begin
            push = 1'b1;
            if (req.last_bit) begin
               if (cfg.crc_enable && seen_upd) begin
                  push_cmd.kind = dbs_pkg::CMD_BIT_TRAILER;
               end
               crc_in  = cfg.crc_init;
               seen_in = 1'b0;
            end else begin
               crc_in  = crc_upd;
               seen_in = seen_upd;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= 16'hFFFF;
         seen_ff <= 1'b0;
      end else begin
         crc_ff  <= crc_in;
         seen_ff <= seen_in;
      end
   end

   a_burst_end_reload: assert property (@(posedge clock) disable iff (reset)
      accept && (req.operation == dbs_pkg::OP_BIT) && req.last_bit
      |=> !seen_ff && crc_ff == $past(cfg.crc_init))
      else $error("CRC state not reloaded after last bit");

endmodule

// ===== rtl/dbs_queue.sv =====
// Short command queue between the front and back ends, held in flip-flops.
// Depends on dbs_pkg.
module dbs_queue #(
   parameter int DEPTH = dbs_pkg::QueueDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dbs_pkg::cmd_type   push_cmd,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output dbs_pkg::cmd_type   head
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [CntW-1:0] FullCount = CntW'(DEPTH);
   localparam logic [PtrW-1:0] LastPtr   = PtrW'(DEPTH - 1);

   dbs_pkg::cmd_type slot_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   assign full      = (count_ff == FullCount);
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from an empty queue");

endmodule

// ===== rtl/dbs_back.sv =====
// Back end: expands queued commands into chip words behind an output register.
// Depends on dbs_pkg and dbs_if.
module dbs_back (
   input  logic               clock,
   input  logic               reset,
   input  dbs_pkg::cfg_type   cfg,
   input  logic               q_valid,
   input  dbs_pkg::cmd_type   q_head,
   output logic               q_pop,
   dbs_rsp_if.source          rsp
);

   localparam int IdxW = dbs_pkg::IdxW;
   localparam int CcW  = dbs_pkg::ChipCountW;
   localparam int WW   = dbs_pkg::ChipWordW;

   dbs_pkg::cmd_type  cur_ff, cur_in;
   logic              active_ff, active_in;
   logic [IdxW-1:0]   idx_ff, idx_in;

   logic              out_valid_ff, out_valid_in;
   logic [WW-1:0]     word_ff, word_in;
   logic [CcW-1:0]    count_ff, count_in;
   logic              pre_ff, pre_in;
   logic              trl_ff, trl_in;
   logic              last_ff, last_in;

   dbs_pkg::cmd_type  src;
   logic [IdxW-1:0]   idx;
   logic [IdxW-1:0]   last_idx;
   logic              is_last;
   logic              have, out_free, step;
   logic [CcW-1:0]    acq_len, reps, spr_len;
   logic [WW-1:0]     acq_mask, spr_mask;
   logic [4:0]        crc_pos;
   logic              chip_bit;

   always_comb begin
      src      = active_ff ? cur_ff : q_head;
      idx      = active_ff ? idx_ff : '0;
      acq_len  = dbs_pkg::clamp_len(cfg.acq_len);
      reps     = dbs_pkg::clamp_len(cfg.acq_repeats) - CcW'(1);
      spr_len  = (cfg.spread_len == '0) ? CcW'(1) : dbs_pkg::clamp_len(cfg.spread_len);
      acq_mask = dbs_pkg::chip_mask(acq_len);
      spr_mask = dbs_pkg::chip_mask(spr_len);
      case (src.kind)
         dbs_pkg::CMD_PREAMBLE:    last_idx = reps[IdxW-1:0];
         dbs_pkg::CMD_BIT_TRAILER: last_idx = IdxW'(dbs_pkg::CrcW);
         default:                  last_idx = '0;
      endcase
      is_last  = (idx == last_idx);
      have     = active_ff || q_valid;
      out_free = !out_valid_ff || rsp.ready;
      step     = have && out_free;
      q_pop    = step && !active_ff;
      // trailer result k (1..16) carries CRC bit 16-k, MSB first
      crc_pos  = 5'd16 - idx[4:0];
      chip_bit = (idx == '0) ? src.bit_val : src.crc[crc_pos[3:0]];
   end

   // sequencing of the current command
   always_comb begin
      cur_in    = cur_ff;
      active_in = active_ff;
      idx_in    = idx_ff;
      if (step) begin
         if (active_ff) begin
            if (is_last) begin
               active_in = 1'b0;
            end else begin
               idx_in = idx_ff + IdxW'(1);
            end
         end else if (!is_last) begin
            cur_in    = q_head;
            active_in = 1'b1;
            idx_in    = IdxW'(1);
         end
      end
   end

   // result formation
   always_comb begin
      out_valid_in = out_free ? step : out_valid_ff;
      word_in  = word_ff;
      count_in = count_ff;
      pre_in   = pre_ff;
      trl_in   = trl_ff;
      last_in  = last_ff;
      if (step) begin
         last_in = is_last;
         if (src.kind == dbs_pkg::CMD_PREAMBLE) begin
            word_in  = cfg.acq_word & acq_mask;
            count_in = acq_len;
            pre_in   = 1'b1;
            trl_in   = 1'b0;
         end else begin
            word_in  = (cfg.spread_word ^ (chip_bit ? spr_mask : '0)) & spr_mask;
            count_in = spr_len;
            pre_in   = 1'b0;
            trl_in   = (idx != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      word_ff  <= word_in;
      count_ff <= count_in;
      pre_ff   <= pre_in;
      trl_ff   <= trl_in;
      last_ff  <= last_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.chip_word   = word_ff;
   assign rsp.chip_count  = count_ff;
   assign rsp.is_preamble = pre_ff;
   assign rsp.is_trailer  = trl_ff;
   assign rsp.run_last    = last_ff;

   a_active_idx: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> idx_ff != '0)
      else $error("active command with zero result index");

   a_trailer_only_in_bit: assert property (@(posedge clock) disable iff (reset)
      step && src.kind == dbs_pkg::CMD_BIT |-> is_last)
      else $error("plain bit command produced more than one result");

endmodule

// ===== rtl/dsss_burst_spreader.sv =====
// Top level of the DSSS burst spreader: register file, front, queue and back.
// Depends on dbs_pkg, dbs_if, dbs_front, dbs_queue and dbs_back.
//
//   channel   direction  handshake            carries
//   req_if    in         valid/ready          operation, frame_bit, in_payload, last_bit
//   rsp_if    out        valid/ready          chip_word, chip_count, flags, run_last
//   APB       in         psel/penable/pready  register writes and reads, 64-bit data
//
// Cycles: the front takes one item per cycle while the command queue has room.
// The back emits one result per cycle while rsp_if is ready: a frame bit gives
// one, a last bit with a trailer gives 17, a start item gives acq_repeats results
// (at most 64, none when the acquisition code is empty); the back's single output
// register sets the sustained rate of one result per cycle.
// Reset is synchronous and clears control state; there is no clearing pass.
// A stalled result holds in the output register while the queue keeps filling.
module dsss_burst_spreader #(
   parameter int QUEUE_DEPTH = dbs_pkg::QueueDepthDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   dbs_req_if.sink                        req_if,
   dbs_rsp_if.source                      rsp_if,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [dbs_pkg::CfgAddrW-1:0]   paddr,
   input  logic [dbs_pkg::CfgDataW-1:0]   pwdata,
   output logic [dbs_pkg::CfgDataW-1:0]   prdata,
   output logic                           pready
);

   localparam int WW  = dbs_pkg::ChipWordW;
   localparam int CcW = dbs_pkg::ChipCountW;
   localparam int CrW = dbs_pkg::CrcW;

   // configuration registers
   logic [WW-1:0]   acq_word_ff, acq_word_in;
   logic [CcW-1:0]  acq_len_ff, acq_len_in;
   logic [CcW-1:0]  acq_repeats_ff, acq_repeats_in;
   logic [WW-1:0]   spr_word_ff, spr_word_in;
   logic [CcW-1:0]  spr_len_ff, spr_len_in;
   logic            crc_en_ff, crc_en_in;
   logic [CrW-1:0]  crc_init_ff, crc_init_in;

   dbs_pkg::reg_index_type reg_idx;
   logic                   wr_en;
   dbs_pkg::cfg_type       cfg;

   logic             push, pop, q_full, q_valid;
   dbs_pkg::cmd_type push_cmd, q_head;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   // registers sit at 8-byte strides
   assign reg_idx = dbs_pkg::reg_index_type'(paddr[dbs_pkg::CfgAddrW-1:3]);

   // decode the write and keep every other register
   always_comb begin
      acq_word_in    = acq_word_ff;
      acq_len_in     = acq_len_ff;
      acq_repeats_in = acq_repeats_ff;
      spr_word_in    = spr_word_ff;
      spr_len_in     = spr_len_ff;
      crc_en_in      = crc_en_ff;
      crc_init_in    = crc_init_ff;
      if (wr_en) begin
         case (reg_idx)
            dbs_pkg::REG_ACQ_WORD:    acq_word_in    = pwdata;
            dbs_pkg::REG_ACQ_LEN:     acq_len_in     = pwdata[CcW-1:0];
            dbs_pkg::REG_ACQ_REPEATS: acq_repeats_in = pwdata[CcW-1:0];
            dbs_pkg::REG_SPREAD_WORD: spr_word_in    = pwdata;
            dbs_pkg::REG_SPREAD_LEN:  spr_len_in     = pwdata[CcW-1:0];
            dbs_pkg::REG_CRC_ENABLE:  crc_en_in      = pwdata[0];
            dbs_pkg::REG_CRC_INIT:    crc_init_in    = pwdata[CrW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acq_word_ff    <= '0;
         acq_len_ff     <= '0;
         acq_repeats_ff <= '0;
         spr_word_ff    <= '0;
         spr_len_ff     <= CcW'(1);
         crc_en_ff      <= 1'b1;
         crc_init_ff    <= 16'hFFFF;
      end else begin
         acq_word_ff    <= acq_word_in;
         acq_len_ff     <= acq_len_in;
         acq_repeats_ff <= acq_repeats_in;
         spr_word_ff    <= spr_word_in;
         spr_len_ff     <= spr_len_in;
         crc_en_ff      <= crc_en_in;
         crc_init_ff    <= crc_init_in;
      end
   end

   // read back the addressed register, zero beyond the list
   always_comb begin
      case (reg_idx)
         dbs_pkg::REG_ACQ_WORD:    prdata = acq_word_ff;
         dbs_pkg::REG_ACQ_LEN:     prdata = dbs_pkg::CfgDataW'(acq_len_ff);
         dbs_pkg::REG_ACQ_REPEATS: prdata = dbs_pkg::CfgDataW'(acq_repeats_ff);
         dbs_pkg::REG_SPREAD_WORD: prdata = spr_word_ff;
         dbs_pkg::REG_SPREAD_LEN:  prdata = dbs_pkg::CfgDataW'(spr_len_ff);
         dbs_pkg::REG_CRC_ENABLE:  prdata = dbs_pkg::CfgDataW'(crc_en_ff);
         dbs_pkg::REG_CRC_INIT:    prdata = dbs_pkg::CfgDataW'(crc_init_ff);
         default:                  prdata = '0;
      endcase
   end

   // bundle the settings for both ends
   always_comb begin
      cfg.acq_word    = acq_word_ff;
      cfg.acq_len     = acq_len_ff;
      cfg.acq_repeats = acq_repeats_ff;
      cfg.spread_word = spr_word_ff;
      cfg.spread_len  = spr_len_ff;
      cfg.crc_enable  = crc_en_ff;
      cfg.crc_init    = crc_init_ff;
   end

   // front: classify each item, advance the CRC, queue a command
   dbs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_if),
      .cfg      (cfg),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   // queue: decouple item acceptance from result delivery
   dbs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (q_head)
   );

   // back: expand each command into chip words
   dbs_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (pop),
      .rsp     (rsp_if)
   );

endmodule
